// ----- rtl/bsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// shared constants and types of the ascending block sorter
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int IO_WIDTH      = 32;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage

// ----- rtl/block_sorter_ascending.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_sorter_ascending
// collects a block of signed keys and returns them in ascending order
// ----------------------------------------------------------------------------
// Keys enter one per cycle and are placed in sorted position at once by a
// row of DEPTH insertion cells, smallest in the first cell. The item with
// tlast set is stored too and ends the block; from the next cycle the keys
// leave from the first cell, one per cycle while m_axis_tready is high, as
// the chain shifts towards its head. No key is taken while a block is
// being returned. Keys beyond DEPTH are dropped and every result of that
// block carries the overflow flag in tuser.
module block_sorter_ascending #(
	parameter int DEPTH     = bsa_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = bsa_pkg::KEY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [bsa_pkg::IO_WIDTH-1:0] s_axis_tdata,  // key_value
	input  logic                         s_axis_tlast,  // block_end
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [bsa_pkg::IO_WIDTH-1:0] m_axis_tdata,  // sorted_value
	output logic                         m_axis_tlast,  // run_end
	output logic                         m_axis_tuser   // overflow
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = bsa_pkg::IO_WIDTH;

	bsa_pkg::state_t     state_q, state_d;
	bsa_pkg::cell_ctrl_t ctrl;
	logic [CW-1:0]       count_q;
	logic                dropped_q;
	logic                in_acc, out_acc, full;

	logic signed [KEY_WIDTH-1:0] in_key;
	logic                        valid_w [DEPTH];
	logic                        fits_w  [DEPTH];
	logic signed [KEY_WIDTH-1:0] key_w   [DEPTH];

	assign s_axis_tready = (state_q == bsa_pkg::ST_FILL);
	assign m_axis_tvalid = (state_q == bsa_pkg::ST_DRAIN);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign full          = (count_q == CW'(DEPTH));
	assign ctrl.ins      = in_acc && !full;
	assign ctrl.pop      = out_acc;

	generate
		if (KEY_WIDTH <= IW) begin : g_in_trunc
			assign in_key = s_axis_tdata[KEY_WIDTH-1:0];
		end else begin : g_in_ext
			assign in_key = {{(KEY_WIDTH-IW){s_axis_tdata[IW-1]}}, s_axis_tdata};
		end
		if (KEY_WIDTH >= IW) begin : g_out_trunc
			assign m_axis_tdata = key_w[0][IW-1:0];
		end else begin : g_out_ext
			assign m_axis_tdata = {{(IW-KEY_WIDTH){key_w[0][KEY_WIDTH-1]}}, key_w[0]};
		end
	endgenerate

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                        pb, pv, nv;
			logic signed [KEY_WIDTH-1:0] pk, nk;
			if (gi == 0) begin : g_head
				assign pb = 1'b0;
				assign pv = 1'b0;
				assign pk = in_key;
			end else begin : g_body
				assign pb = fits_w[gi-1];
				assign pv = valid_w[gi-1];
				assign pk = key_w[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign nv = 1'b0;
				assign nk = key_w[gi];
			end else begin : g_inner
				assign nv = valid_w[gi+1];
				assign nk = key_w[gi+1];
			end
			bsa_cell #(
				.KEY_WIDTH(KEY_WIDTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.new_key   (in_key),
				.prev_fits (pb),
				.prev_valid(pv),
				.prev_key  (pk),
				.next_valid(nv),
				.next_key  (nk),
				.fits      (fits_w[gi]),
				.valid     (valid_w[gi]),
				.key       (key_w[gi])
			);
		end
	endgenerate

	assign m_axis_tlast = (count_q == CW'(1));
	assign m_axis_tuser = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsa_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsa_pkg::ST_FILL: begin
				if (in_acc && s_axis_tlast) state_d = bsa_pkg::ST_DRAIN;
			end
			bsa_pkg::ST_DRAIN: begin
				if (out_acc && m_axis_tlast) state_d = bsa_pkg::ST_FILL;
			end
			default: state_d = bsa_pkg::ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (ctrl.ins) begin
			count_q <= count_q + CW'(1);
		end else if (in_acc) begin
			dropped_q <= 1'b1;
		end else if (out_acc) begin
			count_q <= count_q - CW'(1);
			if (m_axis_tlast) dropped_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	// no key taken while a block is being returned
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted during drain");

	// closing item starts the output
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
		else $error("block end did not start output");

	// final result empties the chain
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
			(!m_axis_tvalid && !valid_w[0] && count_q == '0 && !dropped_q))
		else $error("chain not empty after final result");

	// head cell holds a key whenever a result is shown
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (valid_w[0] && count_q != '0))
		else $error("result shown from an empty chain");
`endif

endmodule

// ----- rtl/bsa_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_cell
// one slot of the insertion chain: holds a key, takes an insert or a shift
// ----------------------------------------------------------------------------
module bsa_cell #(
	parameter int KEY_WIDTH = bsa_pkg::KEY_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsa_pkg::cell_ctrl_t         ctrl,
	input  logic signed [KEY_WIDTH-1:0] new_key,
	input  logic                        prev_fits,
	input  logic                        prev_valid,
	input  logic signed [KEY_WIDTH-1:0] prev_key,
	input  logic                        next_valid,
	input  logic signed [KEY_WIDTH-1:0] next_key,
	output logic                        fits,
	output logic                        valid,
	output logic signed [KEY_WIDTH-1:0] key
);

	logic                        valid_q;
	logic signed [KEY_WIDTH-1:0] key_q;

	// new key belongs in front of this slot
	assign fits  = !valid_q || (new_key < key_q);
	assign valid = valid_q;
	assign key   = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins && fits) begin
			valid_q <= prev_fits ? prev_valid : 1'b1;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && fits) begin
			key_q <= prev_fits ? prev_key : new_key;
		end else if (ctrl.pop) begin
			key_q <= next_key;
		end
	end

endmodule

// ----- test/block_sorter_ascending_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_sorter_ascending_chk
// watches both streams of the block sorter, predicts and compares results
// ----------------------------------------------------------------------------
// Every accepted input key is kept in a local copy of the store, up to DEPTH
// keys; later keys only mark the block as overflowed. When the item with
// tlast is accepted the kept keys are put in ascending signed order and
// queued as expected results. Each accepted output item is compared field by
// field with the oldest queued result.
module block_sorter_ascending_chk #(
	parameter int DEPTH     = bsa_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = bsa_pkg::KEY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [bsa_pkg::IO_WIDTH-1:0] s_tdata,
	input  logic                         s_tlast,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [bsa_pkg::IO_WIDTH-1:0] m_tdata,
	input  logic                         m_tlast,
	input  logic                         m_tuser,
	output int                           fail_count,
	output int                           results_owed
);

	typedef logic signed [KEY_WIDTH-1:0] sort_key_t;

	typedef struct {
		logic [bsa_pkg::IO_WIDTH-1:0] value;
		logic                         run_end;
		logic                         overflow;
	} sorted_item_t;

	sort_key_t         held_keys [DEPTH];
	int                held_count = 0;
	logic              keys_dropped = 1'b0;
	sorted_item_t      sorted_q [$];
	sorted_item_t      oldest;
	sort_key_t         moving;
	logic signed [63:0] wide;
	int                fail_total = 0;
	int                owed = 0;
	int                j;

	assign fail_count   = fail_total;
	assign results_owed = owed;

	task automatic report(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_total < 40) begin
			$display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
		end
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count   = 0;
			keys_dropped = 1'b0;
			sorted_q.delete();
			owed = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sorted_q.size() == 0) begin
					report("unexpected item", m_tdata, '0);
				end else begin
					oldest = sorted_q.pop_front();
					if (m_tdata !== oldest.value)
						report("sorted_value", m_tdata, oldest.value);
					if (m_tlast !== oldest.run_end)
						report("run_end", 32'(m_tlast), 32'(oldest.run_end));
					if (m_tuser !== oldest.overflow)
						report("overflow", 32'(m_tuser), 32'(oldest.overflow));
				end
			end
			if (s_tvalid && s_tready) begin
				// key is sign-extended from 32 bits, then held at KEY_WIDTH
				wide = {{32{s_tdata[31]}}, s_tdata};
				if (held_count < DEPTH) begin
					held_keys[held_count] = wide[KEY_WIDTH-1:0];
					held_count++;
				end else begin
					keys_dropped = 1'b1;
				end
				if (s_tlast) begin
					for (int i = 1; i < held_count; i++) begin
						moving = held_keys[i];
						j = i;
						while (j > 0 && moving < held_keys[j-1]) begin
							held_keys[j] = held_keys[j-1];
							j--;
						end
						held_keys[j] = moving;
					end
					for (int i = 0; i < held_count; i++) begin
						wide = 64'(held_keys[i]);
						oldest.value    = wide[31:0];
						oldest.run_end  = (i == held_count - 1);
						oldest.overflow = keys_dropped;
						sorted_q.push_back(oldest);
					end
					held_count   = 0;
					keys_dropped = 1'b0;
				end
			end
			owed = sorted_q.size();
		end
	end

endmodule

// ----- test/block_sorter_ascending_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_sorter_ascending_tb
// stimulus and verdict for the ascending block sorter
// ----------------------------------------------------------------------------
// Sends directed blocks of extreme, duplicate and reversed keys, then random
// blocks of mostly short length with one exactly full block and one block
// that overflows the store. The sender works in bursts with random gaps, the
// receiver stalls on a changing pattern, and a checker beside the sorter
// predicts and compares every result.
module block_sorter_ascending_tb;

	localparam int DEPTH     = bsa_pkg::DEPTH_DEF;
	localparam int KEY_WIDTH = bsa_pkg::KEY_WIDTH_DEF;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [bsa_pkg::IO_WIDTH-1:0] s_tdata = '0;
	logic                         s_tlast = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [bsa_pkg::IO_WIDTH-1:0] m_tdata;
	logic                         m_tlast;
	logic                         m_tuser;
	int                           fail_count;
	int                           results_owed;

	int burst_left = 0;
	int keys_sent = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;

	block_sorter_ascending #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser)
	);

	block_sorter_ascending_chk #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern, re-chosen at random from four modes
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(8, 80);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (rx_tick % 5 != 0);
		endcase
	end

	task automatic send_key(input logic [31:0] key, input logic last);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				gap        = 0;
				burst_left = $urandom_range(20, 60);
			end else begin
				gap        = $urandom_range(0, 6);
				burst_left = $urandom_range(1, 8);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		keys_sent++;
	endtask

	// hold the sender off until every queued result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return 32'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_block(input int len);
		for (int i = 0; i < len; i++) begin
			send_key(pick_key(), i == len - 1);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single extreme keys
		send_key(32'h8000_0000, 1'b1);
		send_key(32'h7fff_ffff, 1'b1);
		// extremes, zero, one, minus one, duplicate maximum
		send_key(32'h7fff_ffff, 1'b0);
		send_key(32'h0000_0000, 1'b0);
		send_key(32'hffff_ffff, 1'b0);
		send_key(32'h8000_0000, 1'b0);
		send_key(32'h0000_0001, 1'b0);
		send_key(32'h7fff_ffff, 1'b1);
		// equal keys at one in fixed point, then a key just below minus one
		send_key(32'h0001_0000, 1'b0);
		send_key(32'h0001_0000, 1'b0);
		send_key(32'hfffe_ffff, 1'b1);
		// descending pair
		send_key(32'h0000_0005, 1'b0);
		send_key(32'hffff_fffb, 1'b1);
		wait_drained();

		while (keys_sent < 25) begin
			if ($urandom_range(0, 5) == 0)
				send_block($urandom_range(13, DEPTH - 1));
			else
				send_block($urandom_range(1, 12));
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		// store exactly full, then a block whose tail is dropped
		send_block(DEPTH);
		send_block(DEPTH + $urandom_range(1, 3));
		while (keys_sent < 170) begin
			send_block($urandom_range(1, 12));
		end

		wait_drained();
		repeat (DEPTH + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
